FILE: rtl/qed_pkg.sv
`default_nettype none

package qed_pkg;

    localparam int PIN_W      = 4;
    localparam int PORT_W     = 16;
    localparam int TICK_W     = 16;
    localparam int ACTION_W   = 2;
    localparam int STEP_W     = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 4;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_PHASE_A_PIN      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PHASE_B_PIN      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BUTTON_PIN       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_BUTTON_ENABLED   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_INVERT_DIRECTION = 3'd4;

    // Configuration reset values.
    localparam logic [PIN_W-1:0] PHASE_A_PIN_RST = 4'd0;
    localparam logic [PIN_W-1:0] PHASE_B_PIN_RST = 4'd1;
    localparam logic [PIN_W-1:0] BUTTON_PIN_RST  = 4'd2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PORT_EVENT  = 2'd0,
        ACT_EXT_PRESS   = 2'd1,
        ACT_CLEAR_TICKS = 2'd2,
        ACT_CLEAR_PRESS = 2'd3
    } action_t;

    typedef enum logic [STEP_W-1:0] {
        STEP_NONE = 2'd0,
        STEP_CW   = 2'd1,
        STEP_CCW  = 2'd2
    } step_t;

    // Full-step Gray decoder phases.
    typedef enum logic [2:0] {
        PH_START     = 3'd0,
        PH_CW_FINAL  = 3'd1,
        PH_CW_BEGIN  = 3'd2,
        PH_CW_NEXT   = 3'd3,
        PH_CCW_BEGIN = 3'd4,
        PH_CCW_FINAL = 3'd5,
        PH_CCW_NEXT  = 3'd6
    } phase_t;

    localparam logic signed [TICK_W-1:0] TICK_MAX = {1'b0, {(TICK_W-1){1'b1}}};
    localparam logic signed [TICK_W-1:0] TICK_MIN = {1'b1, {(TICK_W-1){1'b0}}};

endpackage

`default_nettype wire

FILE: rtl/quadrature_encoder_decoder_top.sv
`default_nettype none

// Quadrature encoder decoder. Each input transfer carries an action, the pin that
// raised a port event and the raw active-low port word; each one yields exactly one
// result transfer with the handled flag, the step reported by the full-step Gray
// decoder, the saturating signed tick total, the press latch and a changed flag.
// The block takes one item per clock cycle while its result is not stalled: the item
// is held in an input register, and the decoder table step and the tick/press update
// are computed combinationally from it and captured in the result register. A stalled
// result register stalls the input register behind it. Configuration registers are
// written through cfg_wr_en/cfg_addr/cfg_wdata and should only be changed while no
// item is in flight.
module quadrature_encoder_decoder_top (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [qed_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  wire logic [qed_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  wire logic                                  s_valid,
    output      logic                                  s_ready,
    input  wire logic [qed_pkg::ACTION_W-1:0]          s_action,
    input  wire logic [qed_pkg::PIN_W-1:0]             s_event_pin,
    input  wire logic [qed_pkg::PORT_W-1:0]            s_port_word,
    output      logic                                  m_valid,
    input  wire logic                                  m_ready,
    output      logic                                  m_handled,
    output      logic [qed_pkg::STEP_W-1:0]            m_step_seen,
    output      logic signed [qed_pkg::TICK_W-1:0]     m_tick_value,
    output      logic                                  m_press_value,
    output      logic                                  m_changed
);
    import qed_pkg::*;

    // Configuration.
    logic [PIN_W-1:0] phase_a_pin_reg;
    logic [PIN_W-1:0] phase_b_pin_reg;
    logic [PIN_W-1:0] button_pin_reg;
    logic             button_enabled_reg;
    logic             invert_direction_reg;

    // Input register.
    logic              in_valid_reg;
    action_t           in_action_reg;
    logic [PIN_W-1:0]  in_pin_reg;
    logic [PORT_W-1:0] in_word_reg;

    // Decoder state.
    phase_t                     phase_reg;
    phase_t                     phase_next;
    logic signed [TICK_W-1:0]   tick_total_reg;
    logic signed [TICK_W-1:0]   tick_total_next;
    logic                       press_latch_reg;
    logic                       press_latch_next;

    // Result register.
    logic                       out_valid_reg;
    logic                       out_handled_reg;
    step_t                      out_step_reg;
    logic signed [TICK_W-1:0]   out_tick_reg;
    logic                       out_press_reg;
    logic                       out_changed_reg;

    logic                       fire;
    logic [PORT_W-1:0]          word_inv;
    logic                       bit_a;
    logic                       bit_b;
    logic [1:0]                 code;
    logic                       hit_phase;
    logic                       hit_button;
    logic                       phase_step_en;
    phase_t                     table_next;
    step_t                      table_emit;
    logic                       handled;
    step_t                      step;
    logic signed [TICK_W-1:0]   tick_out;
    logic                       press_out;

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    assign word_inv   = ~in_word_reg;
    assign bit_a      = word_inv[phase_a_pin_reg];
    assign bit_b      = word_inv[phase_b_pin_reg];
    assign code       = (phase_a_pin_reg < phase_b_pin_reg) ? {bit_b, bit_a} : {bit_a, bit_b};
    assign hit_phase  = (in_pin_reg == phase_a_pin_reg) || (in_pin_reg == phase_b_pin_reg);
    assign hit_button = button_enabled_reg && (in_pin_reg == button_pin_reg);
    assign phase_step_en = (in_action_reg == ACT_PORT_EVENT) && hit_phase;

    // Decoder table: next phase.
    always_comb begin
        unique case (phase_reg)
            PH_CW_FINAL: begin
                unique case (code)
                    2'd0:    table_next = PH_CW_NEXT;
                    2'd2:    table_next = PH_CW_FINAL;
                    default: table_next = PH_START;
                endcase
            end
            PH_CW_BEGIN: begin
                unique case (code)
                    2'd0:    table_next = PH_CW_NEXT;
                    2'd1:    table_next = PH_CW_BEGIN;
                    default: table_next = PH_START;
                endcase
            end
            PH_CW_NEXT: begin
                unique case (code)
                    2'd0:    table_next = PH_CW_NEXT;
                    2'd1:    table_next = PH_CW_BEGIN;
                    2'd2:    table_next = PH_CW_FINAL;
                    default: table_next = PH_START;
                endcase
            end
            PH_CCW_BEGIN: begin
                unique case (code)
                    2'd0:    table_next = PH_CCW_NEXT;
                    2'd2:    table_next = PH_CCW_BEGIN;
                    default: table_next = PH_START;
                endcase
            end
            PH_CCW_FINAL: begin
                unique case (code)
                    2'd0:    table_next = PH_CCW_NEXT;
                    2'd1:    table_next = PH_CCW_FINAL;
                    default: table_next = PH_START;
                endcase
            end
            PH_CCW_NEXT: begin
                unique case (code)
                    2'd0:    table_next = PH_CCW_NEXT;
                    2'd1:    table_next = PH_CCW_FINAL;
                    2'd2:    table_next = PH_CCW_BEGIN;
                    default: table_next = PH_START;
                endcase
            end
            default: begin
                // The start state; the unused phase code behaves the same way.
                unique case (code)
                    2'd1:    table_next = PH_CW_BEGIN;
                    2'd2:    table_next = PH_CCW_BEGIN;
                    default: table_next = PH_START;
                endcase
            end
        endcase
    end

    // Decoder table: a step is reported only on the final transition to start.
    always_comb begin
        unique case (phase_reg)
            PH_CW_FINAL:  table_emit = (code == 2'd3) ? STEP_CW : STEP_NONE;
            PH_CCW_FINAL: table_emit = (code == 2'd3) ? STEP_CCW : STEP_NONE;
            default:      table_emit = STEP_NONE;
        endcase
    end

    always_comb begin
        logic up;
        up               = 1'b0;
        handled          = 1'b0;
        step             = STEP_NONE;
        phase_next       = phase_reg;
        tick_total_next  = tick_total_reg;
        press_latch_next = press_latch_reg;
        tick_out         = tick_total_reg;
        press_out        = press_latch_reg;

        unique case (in_action_reg)
            ACT_PORT_EVENT: begin
                if (phase_step_en) begin
                    handled    = 1'b1;
                    phase_next = table_next;
                    step       = table_emit;
                    if (table_emit != STEP_NONE) begin
                        up = (table_emit == STEP_CW) ^ invert_direction_reg;
                        if (up && tick_total_reg != TICK_MAX) begin
                            tick_total_next = tick_total_reg + TICK_W'(1);
                        end else if (!up && tick_total_reg != TICK_MIN) begin
                            tick_total_next = tick_total_reg - TICK_W'(1);
                        end
                    end
                end else if (hit_button) begin
                    handled = 1'b1;
                    if (word_inv[button_pin_reg]) begin
                        press_latch_next = 1'b1;
                    end
                end
                tick_out  = tick_total_next;
                press_out = press_latch_next;
            end
            ACT_EXT_PRESS: begin
                press_latch_next = 1'b1;
                press_out        = 1'b1;
            end
            ACT_CLEAR_TICKS: begin
                tick_total_next = '0;
            end
            default: begin
                press_latch_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_a_pin_reg      <= PHASE_A_PIN_RST;
            phase_b_pin_reg      <= PHASE_B_PIN_RST;
            button_pin_reg       <= BUTTON_PIN_RST;
            button_enabled_reg   <= 1'b0;
            invert_direction_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_PHASE_A_PIN:      phase_a_pin_reg      <= cfg_wdata;
                CFG_PHASE_B_PIN:      phase_b_pin_reg      <= cfg_wdata;
                CFG_BUTTON_PIN:       button_pin_reg       <= cfg_wdata;
                CFG_BUTTON_ENABLED:   button_enabled_reg   <= cfg_wdata[0];
                CFG_INVERT_DIRECTION: invert_direction_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_START;
            tick_total_reg  <= '0;
            press_latch_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg   <= 1'b1;
                phase_reg       <= phase_next;
                tick_total_reg  <= tick_total_next;
                press_latch_reg <= press_latch_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg <= action_t'(s_action);
            in_pin_reg    <= s_event_pin;
            in_word_reg   <= s_port_word;
        end
        if (fire) begin
            out_handled_reg <= handled;
            out_step_reg    <= step;
            out_tick_reg    <= tick_out;
            out_press_reg   <= press_out;
            out_changed_reg <= (tick_total_next != '0) || press_latch_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_handled     = out_handled_reg;
    assign m_step_seen   = out_step_reg;
    assign m_tick_value  = out_tick_reg;
    assign m_press_value = out_press_reg;
    assign m_changed     = out_changed_reg;

    // A reported step always comes from a handled port event.
    a_step_handled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_step_seen != STEP_NONE) |-> m_handled)
        else $error("step reported without a handled event");

    // The changed flag reflects the state that the item left behind.
    a_changed_state: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> (m_changed == ((tick_total_reg != '0) || press_latch_reg)))
        else $error("changed flag disagrees with state");

    a_clear_ticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_action_reg == ACT_CLEAR_TICKS) |=> (tick_total_reg == '0))
        else $error("tick total not cleared");

    a_clear_press: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_action_reg == ACT_CLEAR_PRESS) |=> !press_latch_reg)
        else $error("press latch not cleared");

    // Only a handled phase event moves the decoder.
    a_phase_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !phase_step_en) |=> $stable(phase_reg))
        else $error("decoder phase moved without a phase event");

endmodule

`default_nettype wire
